// File: sv/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg: shared types and constants of the spot light cone falloff core
// Payload structs, register indexes, cone region codes and datapath widths.
// ----------------------------------------------------------------------------
package slc_pkg;

  // Input beat: one surface point, signed Q16.8 per axis.
  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
  } slc_in_t;

  // Result beat.
  typedef struct packed {
    logic [15:0] lit_intensity;
    logic [1:0]  cone_region;
  } slc_out_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_LIGHT_POS_X     = 3'd0;
  localparam logic [2:0] REG_LIGHT_POS_Y     = 3'd1;
  localparam logic [2:0] REG_LIGHT_POS_Z     = 3'd2;
  localparam logic [2:0] REG_LIGHT_DIR       = 3'd3;
  localparam logic [2:0] REG_OUTER_COS       = 3'd4;
  localparam logic [2:0] REG_INNER_COS       = 3'd5;
  localparam logic [2:0] REG_LIGHT_INTENSITY = 3'd6;

  // Cone region codes.
  localparam logic [1:0] REGION_OUTSIDE = 2'd0;
  localparam logic [1:0] REGION_BAND    = 2'd1;
  localparam logic [1:0] REGION_INSIDE  = 2'd2;

  // Square root datapath: radicand is the squared length times 4096.
  localparam int RAD_W  = 62;
  localparam int ROOT_W = 31;
  localparam int MAG_W  = 41;

  // Sign and magnitude of the dot product, carried beside the square root.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } slc_tag_t;

endpackage

// File: sv/slc_isqrt.sv
// ----------------------------------------------------------------------------
// slc_isqrt: pipelined integer square root
// One result bit per stage, a new radicand may enter every cycle. A tag word
// travels with each radicand and leaves with its root.
// ----------------------------------------------------------------------------
module slc_isqrt import slc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [RAD_W-1:0]  in_rad,
  input  slc_tag_t          in_tag,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root,
  output slc_tag_t          out_tag
);

  localparam int REM_W = RAD_W + 1;

  logic              vld_r  [0:ROOT_W];
  logic [REM_W-1:0]  rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0] root_r [0:ROOT_W];
  slc_tag_t          tag_r  [0:ROOT_W];

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= {1'b0, in_rad};
    root_r[0] <= '0;
    tag_r[0]  <= in_tag;
  end

  // One stage per root bit, most significant first.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int BIT = ROOT_W - 1 - k;
    logic [REM_W-1:0] trial;
    logic             take;

    // Growth of the square when this bit is set: 2*root*2^b + 4^b.
    assign trial = ({{(REM_W-ROOT_W){1'b0}}, root_r[k]} << (BIT + 1))
                 + (REM_W'(1) << (2 * BIT));
    assign take  = rem_r[k] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1]  <= take ? rem_r[k] - trial : rem_r[k];
      root_r[k+1] <= take ? (root_r[k] | (ROOT_W'(1) << BIT)) : root_r[k];
      tag_r[k+1]  <= tag_r[k];
    end
  end

  assign out_vld  = vld_r[ROOT_W];
  assign out_root = root_r[ROOT_W];
  assign out_tag  = tag_r[ROOT_W];

endmodule

// File: sv/spot_light_cone_falloff_core.sv
// ----------------------------------------------------------------------------
// spot_light_cone_falloff_core: spotlight cone test with linear falloff
// Takes one surface point per beat, forms the cosine between the point to
// light vector and the spot direction, and returns the lit intensity and the
// cone region.
//
//   channel  | ports                         | handshake
//   ---------+-------------------------------+-----------------------------
//   input    | start, busy, in_point         | start high while busy low
//   result   | out_strobe, out_result        | one cycle, no back pressure
//   config   | cfg_we, cfg_idx, cfg_wdata    | write on cfg_we, no wait
//
// A point enters every cycle; busy is always low. Each result passes through
// the 31-stage square root, the 15-stage cosine divider and the 16-stage
// falloff divider. Reset clears only the valid bits and loads the register
// reset values. The receiver cannot stall, so beats flow straight through the
// pipeline.
// ----------------------------------------------------------------------------
module spot_light_cone_falloff_core import slc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  slc_in_t     in_point,
  output logic        out_strobe,
  output slc_out_t    out_result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [47:0] cfg_wdata
);

  localparam int DVD_W = MAG_W + 6;
  localparam int CQ_W  = 15;
  localparam int PR_W  = 32;
  localparam int LQ_W  = 16;

  // Configuration registers.
  logic signed [23:0] lpx_r, lpy_r, lpz_r;
  logic [47:0]        ldir_r;
  logic signed [15:0] outer_r, inner_r;
  logic [15:0]        inten_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpx_r   <= '0;
      lpy_r   <= '0;
      lpz_r   <= '0;
      ldir_r  <= '0;
      outer_r <= '0;
      inner_r <= 16'sd16384;
      inten_r <= 16'd4096;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_LIGHT_POS_X:     lpx_r   <= cfg_wdata[23:0];
        REG_LIGHT_POS_Y:     lpy_r   <= cfg_wdata[23:0];
        REG_LIGHT_POS_Z:     lpz_r   <= cfg_wdata[23:0];
        REG_LIGHT_DIR:       ldir_r  <= cfg_wdata;
        REG_OUTER_COS:       outer_r <= cfg_wdata[15:0];
        REG_INNER_COS:       inner_r <= cfg_wdata[15:0];
        REG_LIGHT_INTENSITY: inten_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: point to light vector.
  logic               v1_r;
  logic signed [24:0] dx1_r, dy1_r, dz1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    dx1_r <= {lpx_r[23], lpx_r} - {in_point.point_x[23], in_point.point_x};
    dy1_r <= {lpy_r[23], lpy_r} - {in_point.point_y[23], in_point.point_y};
    dz1_r <= {lpz_r[23], lpz_r} - {in_point.point_z[23], in_point.point_z};
  end

  // Stage 2: squares and direction products.
  logic               v2_r;
  logic signed [49:0] sqx_r, sqy_r, sqz_r;
  logic signed [40:0] prx_r, pry_r, prz_r;
  logic signed [15:0] ux, uy, uz;

  assign ux = ldir_r[15:0];
  assign uy = ldir_r[31:16];
  assign uz = ldir_r[47:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sqx_r <= dx1_r * dx1_r;
    sqy_r <= dy1_r * dy1_r;
    sqz_r <= dz1_r * dz1_r;
    prx_r <= ux * dx1_r;
    pry_r <= uy * dy1_r;
    prz_r <= uz * dz1_r;
  end

  // Stage 3: squared length and dot product.
  logic               v3_r;
  logic [49:0]        s3_r;
  logic signed [41:0] p3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_r <= 50'(sqx_r) + 50'(sqy_r) + 50'(sqz_r);
    p3_r <= 42'(prx_r) + 42'(pry_r) + 42'(prz_r);
  end

  // Square root of the scaled length, with the dot product beside it.
  slc_tag_t          sq_in_tag, sq_tag;
  logic [41:0]       p3_abs;
  logic              sq_vld;
  logic [ROOT_W-1:0] len;

  assign p3_abs        = p3_r[41] ? -p3_r : p3_r;
  assign sq_in_tag.neg = p3_r[41];
  assign sq_in_tag.mag = p3_abs[MAG_W-1:0];

  slc_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v3_r),
    .in_rad   ({s3_r, 12'b0}),
    .in_tag   (sq_in_tag),
    .out_vld  (sq_vld),
    .out_root (len),
    .out_tag  (sq_tag)
  );

  // Cosine divider setup: saturation and zero length are found up front.
  logic              cv_r   [0:CQ_W];
  logic [DVD_W-1:0]  crem_r [0:CQ_W];
  logic [CQ_W-1:0]   cq_r   [0:CQ_W];
  logic [ROOT_W-1:0] clen_r [0:CQ_W];
  logic              cneg_r [0:CQ_W];
  logic              covf_r [0:CQ_W];
  logic              czero_r[0:CQ_W];
  logic [DVD_W-1:0]  c_dvd;

  assign c_dvd = {sq_tag.mag, 6'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else begin
      cv_r[0] <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    crem_r[0]  <= c_dvd;
    cq_r[0]    <= '0;
    clen_r[0]  <= len;
    cneg_r[0]  <= sq_tag.neg;
    covf_r[0]  <= c_dvd >= {1'b0, len, 15'b0};
    czero_r[0] <= len == '0;
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < CQ_W; k++) begin : g_cdiv
    localparam int BIT = CQ_W - 1 - k;
    logic [DVD_W-1:0] dsh;
    logic             take;

    assign dsh  = {{(DVD_W-ROOT_W){1'b0}}, clen_r[k]} << BIT;
    assign take = crem_r[k] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[k+1] <= 1'b0;
      end else begin
        cv_r[k+1] <= cv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      crem_r[k+1]  <= take ? crem_r[k] - dsh : crem_r[k];
      cq_r[k+1]    <= take ? (cq_r[k] | (CQ_W'(1) << BIT)) : cq_r[k];
      clen_r[k+1]  <= clen_r[k];
      cneg_r[k+1]  <= cneg_r[k];
      covf_r[k+1]  <= covf_r[k];
      czero_r[k+1] <= czero_r[k];
    end
  end

  // Signed, saturated cosine.
  logic               cos_v_r;
  logic signed [15:0] cos_r;
  logic signed [15:0] cos_nxt;

  always_comb begin
    if (czero_r[CQ_W]) begin
      cos_nxt = '0;
    end else if (covf_r[CQ_W]) begin
      cos_nxt = cneg_r[CQ_W] ? 16'sh8000 : 16'sh7FFF;
    end else if (cneg_r[CQ_W]) begin
      cos_nxt = -$signed({1'b0, cq_r[CQ_W]});
    end else begin
      cos_nxt = $signed({1'b0, cq_r[CQ_W]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_v_r <= 1'b0;
    end else begin
      cos_v_r <= cv_r[CQ_W];
    end
  end

  always_ff @(posedge clk) begin
    cos_r <= cos_nxt;
  end

  // Region decision and falloff numerator product.
  logic               below, full;
  logic signed [16:0] num_s, den_s;
  logic [1:0]         region_nxt;

  assign below = cos_r < outer_r;
  assign full  = (cos_r > inner_r) || (inner_r == outer_r);
  assign num_s = {cos_r[15], cos_r} - {outer_r[15], outer_r};
  assign den_s = {inner_r[15], inner_r} - {outer_r[15], outer_r};

  always_comb begin
    if (below) begin
      region_nxt = REGION_OUTSIDE;
    end else if (full) begin
      region_nxt = REGION_INSIDE;
    end else begin
      region_nxt = REGION_BAND;
    end
  end

  logic            fv_r   [0:LQ_W];
  logic [1:0]      freg_r [0:LQ_W];
  logic [PR_W-1:0] frem_r [0:LQ_W];
  logic [15:0]     fden_r [0:LQ_W];
  logic [LQ_W-1:0] fq_r   [0:LQ_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r[0] <= 1'b0;
    end else begin
      fv_r[0] <= cos_v_r;
    end
  end

  always_ff @(posedge clk) begin
    freg_r[0] <= region_nxt;
    frem_r[0] <= inten_r * num_s[15:0];
    fden_r[0] <= den_s[15:0];
    fq_r[0]   <= '0;
  end

  // Falloff division: intensity times offset over band width.
  for (genvar k = 0; k < LQ_W; k++) begin : g_fdiv
    localparam int BIT = LQ_W - 1 - k;
    logic [PR_W-1:0] dsh;
    logic            take;

    assign dsh  = {16'b0, fden_r[k]} << BIT;
    assign take = frem_r[k] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fv_r[k+1] <= 1'b0;
      end else begin
        fv_r[k+1] <= fv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      frem_r[k+1] <= take ? frem_r[k] - dsh : frem_r[k];
      fq_r[k+1]   <= take ? (fq_r[k] | (LQ_W'(1) << BIT)) : fq_r[k];
      fden_r[k+1] <= fden_r[k];
      freg_r[k+1] <= freg_r[k];
    end
  end

  // Output register.
  logic     out_v_r;
  slc_out_t out_r;
  logic [15:0] lit_nxt;

  always_comb begin
    case (freg_r[LQ_W])
      REGION_BAND:   lit_nxt = fq_r[LQ_W];
      REGION_INSIDE: lit_nxt = inten_r;
      default:       lit_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= fv_r[LQ_W];
    end
  end

  always_ff @(posedge clk) begin
    out_r.lit_intensity <= lit_nxt;
    out_r.cone_region   <= freg_r[LQ_W];
  end

  assign out_strobe = out_v_r;
  assign out_result = out_r;

endmodule

// File: sim/tb_spot_light_cone_falloff_core.sv
// ----------------------------------------------------------------------------
// tb_spot_light_cone_falloff_core: self-checking bench for the spotlight core
// Drives surface points through the command port under several light
// settings, predicts each cosine, region and intensity in the bench, and
// checks every result beat in order against the prediction.
// ----------------------------------------------------------------------------
module tb_spot_light_cone_falloff_core;
  import slc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index with no register behind it.
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  slc_in_t     in_point;
  logic        out_strobe;
  slc_out_t    out_result;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [47:0] cfg_wdata;

  spot_light_cone_falloff_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_point   (in_point),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  // Bench copy of the light registers.
  logic signed [23:0] light_x, light_y, light_z;
  logic [47:0]        light_dir;
  logic signed [15:0] cos_outer, cos_inner;
  logic [15:0]        light_level;

  slc_in_t  point_q[$];
  slc_out_t shade_expect_q[$];
  int       n_accepted, n_checked, n_errors;
  int       region_seen[3];
  bit       idle_on;
  bit       hold_points;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("FAIL spot_light_cone_falloff_core");
    $finish;
  end

  // Integer square root by the bitwise method.
  function automatic longint unsigned int_root(longint unsigned x);
    longint unsigned res, bit_w;
    res   = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w >>= 2;
    while (bit_w != 0) begin
      if (x >= res + bit_w) begin
        x   -= res + bit_w;
        res  = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // Cosine, cone region and lit intensity of one point.
  function automatic slc_out_t shade_point(slc_in_t p);
    longint          dx, dy, dz, ux, uy, uz, dotp, c, oc, ic;
    longint unsigned sq, len, mag, q;
    slc_out_t        r;
    dx   = longint'(light_x) - longint'(p.point_x);
    dy   = longint'(light_y) - longint'(p.point_y);
    dz   = longint'(light_z) - longint'(p.point_z);
    ux   = longint'($signed(light_dir[15:0]));
    uy   = longint'($signed(light_dir[31:16]));
    uz   = longint'($signed(light_dir[47:32]));
    sq   = dx * dx + dy * dy + dz * dz;
    len  = int_root(sq << 12);
    dotp = ux * dx + uy * dy + uz * dz;
    mag  = (dotp < 0) ? -dotp : dotp;
    oc   = longint'(cos_outer);
    ic   = longint'(cos_inner);
    if (len == 0) begin
      c = 0;
    end else begin
      q = (mag << 6) / len;
      if (dotp < 0) c = (q > 32768) ? -32768 : -longint'(q);
      else          c = (q > 32767) ? 32767 : longint'(q);
    end
    if (c < oc) begin
      r.lit_intensity = '0;
      r.cone_region   = REGION_OUTSIDE;
    end else if (c > ic || ic == oc) begin
      r.lit_intensity = light_level;
      r.cone_region   = REGION_INSIDE;
    end else begin
      r.lit_intensity = 16'((longint'(light_level) * (c - oc)) / (ic - oc));
      r.cone_region   = REGION_BAND;
    end
    return r;
  endfunction

  // Driver: present the next queued point once the current beat is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        shade_expect_q.push_back(shade_point(in_point));
        n_accepted++;
      end
      if (!start || !busy) begin
        if (point_q.size() != 0 && !hold_points &&
            !(idle_on && $urandom_range(99) < 26)) begin
          start    <= 1'b1;
          in_point <= point_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    slc_out_t want;
    if (rst_n && out_strobe) begin
      if (shade_expect_q.size() == 0) begin
        $error("result beat with no point outstanding: %p", out_result);
        n_errors++;
      end else begin
        want = shade_expect_q.pop_front();
        if (out_result.lit_intensity !== want.lit_intensity) begin
          $error("lit_intensity: expected %0d, got %0d",
                 want.lit_intensity, out_result.lit_intensity);
          n_errors++;
        end
        if (out_result.cone_region !== want.cone_region) begin
          $error("cone_region: expected %0d, got %0d",
                 want.cone_region, out_result.cone_region);
          n_errors++;
        end
        if (want.cone_region < 3) region_seen[want.cone_region]++;
        n_checked++;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_LIGHT_POS_X:     light_x     = v[23:0];
      REG_LIGHT_POS_Y:     light_y     = v[23:0];
      REG_LIGHT_POS_Z:     light_z     = v[23:0];
      REG_LIGHT_DIR:       light_dir   = v;
      REG_OUTER_COS:       cos_outer   = v[15:0];
      REG_INNER_COS:       cos_inner   = v[15:0];
      REG_LIGHT_INTENSITY: light_level = v[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_point(int x, int y, int z);
    slc_in_t p;
    p.point_x = x[23:0];
    p.point_y = y[23:0];
    p.point_z = z[23:0];
    point_q.push_back(p);
  endtask

  // Mostly points near the light so the cosine spans the whole cone.
  task automatic push_random_point();
    int k, sel;
    sel = $urandom_range(99);
    k   = $urandom_range(22);
    if (sel < 5) begin
      push_point(light_x, light_y, light_z);
    end else if (sel < 20) begin
      push_point($urandom, $urandom, $urandom);
    end else begin
      push_point(light_x + $signed($urandom_range(2 << k)) - (1 << k),
                 light_y + $signed($urandom_range(2 << k)) - (1 << k),
                 light_z + $signed($urandom_range(2 << k)) - (1 << k));
    end
  endtask

  // Wait until every queued point is taken and every result is back.
  task automatic drain();
    do @(negedge clk);
    while (point_q.size() != 0 || start || shade_expect_q.size() != 0);
  endtask

  // Random direction of roughly unit length.
  function automatic logic [47:0] unit_dir();
    longint ux, uy, uz, rest;
    ux   = $signed($urandom_range(32768)) - 16384;
    rest = 268435456 - ux * ux;
    uy   = $signed($urandom_range(32'(2 * int_root(rest)))) - longint'(int_root(rest));
    rest = rest - uy * uy;
    uz   = longint'(int_root(rest < 0 ? 0 : rest));
    if ($urandom_range(1)) uz = -uz;
    return {16'(uz), 16'(uy), 16'(ux)};
  endfunction

  initial begin
    int oc, ic, base;
    rst_n = 1'b0; start = 1'b0; in_point = '0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    idle_on = 1'b1; hold_points = 1'b0;
    n_accepted = 0; n_checked = 0; n_errors = 0;
    region_seen = '{0, 0, 0};
    light_x = 0; light_y = 0; light_z = 0; light_dir = '0;
    cos_outer = 0; cos_inner = 16384; light_level = 4096;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: zero direction gives cosine 0, on the outer cutoff.
    push_point(256, -512, 77);
    drain();

    // Directed: spot along +x from the origin.
    write_reg(REG_LIGHT_DIR, {16'sd0, 16'sd0, 16'sd16384});
    write_reg(REG_OUTER_COS, 48'(16'sd0));
    write_reg(REG_INNER_COS, 48'(16'sd16384));
    write_reg(REG_LIGHT_INTENSITY, 48'd65535);
    write_reg(REG_UNMAPPED, '1);                // unmapped index, ignored
    push_point(-100, 0, 0);                     // on the inner cutoff
    push_point(0, 100, 0);                      // on the outer cutoff
    push_point(100, 0, 0);                      // behind the light
    push_point(-100, 100, 0);                   // in the band
    push_point(0, 0, 0);                        // point at the light
    push_point(-8388608, -8388608, -8388608);
    push_point(8388607, 8388607, 8388607);
    push_point(-8388608, 8388607, 0);
    push_point(-1, 0, 0);
    drain();
    // Light at the extremes with an oversized direction: cosine saturates.
    write_reg(REG_LIGHT_POS_X, 48'h7FFFFF);
    write_reg(REG_LIGHT_POS_Y, 48'h800000);
    write_reg(REG_LIGHT_POS_Z, 48'h7FFFFF);
    write_reg(REG_LIGHT_DIR, {16'h7FFF, 16'h8000, 16'h7FFF});
    write_reg(REG_OUTER_COS, 48'(-16'sd16384));
    write_reg(REG_INNER_COS, 48'(16'sd16384));
    write_reg(REG_LIGHT_INTENSITY, 48'd0);
    push_point(-8388608, 8388607, -8388608);
    push_point(8388607, -8388608, 8388607);
    push_point(0, 0, 0);
    push_point(8388607, 8388607, 8388607);
    drain();
    // Equal cutoffs: a cosine on both gives full intensity.
    write_reg(REG_LIGHT_POS_X, '0);
    write_reg(REG_LIGHT_POS_Y, '0);
    write_reg(REG_LIGHT_POS_Z, '0);
    write_reg(REG_LIGHT_DIR, {16'sd0, 16'sd0, 16'sd16384});
    write_reg(REG_OUTER_COS, 48'(16'sd16384));
    write_reg(REG_INNER_COS, 48'(16'sd16384));
    write_reg(REG_LIGHT_INTENSITY, 48'd4660);
    push_point(-100, 0, 0);
    push_point(-100, 3, 0);
    drain();

    // Random phases, each under its own light setting.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_LIGHT_POS_X, (ph == 2) ? 48'h7FFFFF : 48'($urandom));
      write_reg(REG_LIGHT_POS_Y, (ph == 2) ? 48'h800000 : 48'($urandom));
      write_reg(REG_LIGHT_POS_Z, (ph == 2) ? 48'h000000 : 48'($urandom));
      if (ph == 3)      write_reg(REG_LIGHT_DIR, 48'({$urandom, $urandom}));
      else if (ph == 4) write_reg(REG_LIGHT_DIR, '0);
      else              write_reg(REG_LIGHT_DIR, unit_dir());
      oc = $signed($urandom_range(32768)) - 16384;
      ic = $signed($urandom_range(32768)) - 16384;
      if (ph == 0)      begin oc = -16384; ic = 16384; end
      else if (ph == 1) begin oc = 16384;  ic = 16384; end
      else if (ph == 7) begin oc = 10000;  ic = 10000; end
      else if (ph == 8) begin if (oc < ic) begin int t; t = oc; oc = ic; ic = t; end end
      else if (oc > ic) begin int t; t = oc; oc = ic; ic = t; end
      write_reg(REG_OUTER_COS, 48'(16'(oc)));
      write_reg(REG_INNER_COS, 48'(16'(ic)));
      write_reg(REG_LIGHT_INTENSITY,
                (ph == 5) ? 48'd65535 : (ph == 6) ? 48'd0 : 48'($urandom_range(65535)));
      if (ph == 9) write_reg(REG_UNMAPPED, 48'({$urandom, $urandom}));
      idle_on = (ph != 5);
      @(negedge clk);
      base = n_accepted;
      for (int i = 0; i < 90; i++) push_random_point();
      // Hold the sender until the pipeline has fully drained once.
      if (ph == 6) begin
        while (n_accepted < base + 40) @(negedge clk);
        hold_points = 1'b1;
        while (shade_expect_q.size() != 0 || start) @(negedge clk);
        hold_points = 1'b0;
      end
      drain();
    end

    repeat (80) @(posedge clk);
    if (shade_expect_q.size() != 0) begin
      $error("%0d results never arrived", shade_expect_q.size());
      n_errors++;
    end
    $display("Checked %0d results over 14 light settings.", n_checked);
    $display("Regions: outside %0d, band %0d, inside %0d.",
             region_seen[0], region_seen[1], region_seen[2]);
    if (n_errors == 0) $display("PASS spot_light_cone_falloff_core");
    else               $display("FAIL spot_light_cone_falloff_core");
    $finish;
  end

endmodule

// File: spot_light_cone_falloff_core.f
sv/slc_pkg.sv
sv/slc_isqrt.sv
sv/spot_light_cone_falloff_core.sv
sim/tb_spot_light_cone_falloff_core.sv
